// ===== hdl/mpl_pkg.sv =====
// ----------------------------------------------------------------------------
// mpl_pkg
// Shared types and constants of the mutex pool lock unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mpl_pkg;

  // pool geometry; slot and task fields are five bits wide
  localparam int SlotCount = 32;
  localparam int TaskCount = 32;
  localparam int SlotW     = 5;
  localparam int TaskW     = 5;

  typedef enum logic [1:0] {
    FuncAlloc  = 2'd0,
    FuncFree   = 2'd1,
    FuncLock   = 2'd2,
    FuncUnlock = 2'd3
  } func_e;

  typedef struct packed {
    func_e            func;
    logic [SlotW-1:0] slot_index;
    logic [TaskW-1:0] task_id;
  } req_t;

  typedef struct packed {
    logic             success;
    logic [SlotW-1:0] slot_out;
    logic             is_locked;
    logic [TaskW-1:0] owner_task;
  } rsp_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic exec;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_stall;
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== hdl/mpl_ctrl.sv =====
// ----------------------------------------------------------------------------
// mpl_ctrl
// Request sequencer: takes a request, then executes it once the result
// register can take the outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module mpl_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  mpl_pkg::dp_sts_t    sts_i,
  output mpl_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StExec = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    in_ready_o     = 1'b0;
    cmd_o.load_req = 1'b0;
    cmd_o.exec     = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = StExec;
        end
      end
      StExec: begin
        // wait while the previous result is still held
        if (!sts_i.out_stall) begin
          cmd_o.exec = 1'b1;
          state_d    = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mpl_dp.sv =====
// ----------------------------------------------------------------------------
// mpl_dp
// Pool datapath: request register, free map, lock and owner store, lowest
// free slot search and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mpl_dp (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  mpl_pkg::ctrl_cmd_t  cmd_i,
  output mpl_pkg::dp_sts_t    sts_o,
  input  mpl_pkg::req_t       in_req_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output mpl_pkg::rsp_t       out_rsp_o
);

  mpl_pkg::req_t                  req_q;
  logic [mpl_pkg::SlotCount-1:0]  free_q, free_d;
  logic [mpl_pkg::SlotCount-1:0]  lock_q, lock_d;
  logic [mpl_pkg::TaskW-1:0]      owner_q [mpl_pkg::SlotCount];
  logic                           owner_we;
  logic [mpl_pkg::TaskW-1:0]      owner_wdata;
  logic                           out_valid_q, out_valid_d;
  mpl_pkg::rsp_t                  rsp_q, rsp_d;

  logic [mpl_pkg::SlotW-1:0]      enc_slot;
  logic                           any_free;
  logic [mpl_pkg::SlotW-1:0]      rd_slot;
  logic                           slot_ok;
  logic                           task_ok;
  logic                           ok;
  logic                           cur_lock;
  logic [mpl_pkg::TaskW-1:0]      cur_owner;

  assign sts_o.out_stall = out_valid_q && !out_ready_i;

  // lowest free slot
  always_comb begin
    enc_slot = '0;
    for (int i = mpl_pkg::SlotCount - 1; i >= 0; i--) begin
      if (free_q[i]) begin
        enc_slot = mpl_pkg::SlotW'(i);
      end
    end
  end

  assign any_free = |free_q;
  assign rd_slot  = (req_q.func == mpl_pkg::FuncAlloc) ? enc_slot : req_q.slot_index;
  assign slot_ok  = (req_q.func == mpl_pkg::FuncAlloc) ||
                    (int'(req_q.slot_index) < mpl_pkg::SlotCount);
  assign task_ok  = int'(req_q.task_id) < mpl_pkg::TaskCount;
  assign cur_lock  = lock_q[rd_slot];
  assign cur_owner = owner_q[rd_slot];

  always_comb begin
    free_d      = free_q;
    lock_d      = lock_q;
    owner_we    = 1'b0;
    owner_wdata = '0;
    ok          = 1'b0;
    unique case (req_q.func)
      mpl_pkg::FuncAlloc: begin
        ok = any_free;
        if (any_free) begin
          free_d[rd_slot] = 1'b0;
        end
      end
      mpl_pkg::FuncFree: begin
        ok = slot_ok && !free_q[rd_slot];
        if (ok) begin
          free_d[rd_slot] = 1'b1;
        end
      end
      mpl_pkg::FuncLock: begin
        ok = slot_ok && !cur_lock && task_ok;
        if (ok) begin
          lock_d[rd_slot] = 1'b1;
          owner_we        = 1'b1;
          owner_wdata     = req_q.task_id;
        end
      end
      mpl_pkg::FuncUnlock: begin
        ok = slot_ok && cur_lock;
        if (ok) begin
          lock_d[rd_slot] = 1'b0;
          owner_we        = 1'b1;
        end
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  // result reflects the slot after the request
  always_comb begin
    rsp_d.success    = ok;
    rsp_d.slot_out   = (req_q.func == mpl_pkg::FuncAlloc && !any_free) ? '0 : rd_slot;
    rsp_d.is_locked  = slot_ok ? lock_d[rd_slot] : 1'b0;
    rsp_d.owner_task = !slot_ok ? '0 : (owner_we ? owner_wdata : cur_owner);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_q      <= '1;
      lock_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < mpl_pkg::SlotCount; i++) begin
        owner_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.exec) begin
        free_q <= free_d;
        lock_q <= lock_d;
        if (owner_we) begin
          owner_q[rd_slot] <= owner_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_req_i;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

  // never overwrite a result that has not been taken
  a_exec_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec |-> !(out_valid_q && !out_ready_i))
    else $error("result register overwritten");

  // a granted alloc leaves its slot marked taken
  a_alloc_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && req_q.func == mpl_pkg::FuncAlloc && any_free
    |=> !free_q[$past(enc_slot)])
    else $error("allocated slot still free");

  // a granted lock leaves the slot locked
  a_lock_sets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.exec && req_q.func == mpl_pkg::FuncLock && ok
    |=> lock_q[$past(rd_slot)])
    else $error("locked slot not marked");

  // an unlocked slot never carries an owner
  a_owner_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cur_lock |-> cur_owner == '0)
    else $error("owner left on unlocked slot");

endmodule

`default_nettype wire

// ===== hdl/mutex_pool_lock_unit.sv =====
// ----------------------------------------------------------------------------
// mutex_pool_lock_unit
// Pool of mutex slots with alloc, free, lock and unlock requests.
// ----------------------------------------------------------------------------
// Each request is first registered as a transaction; then, in the execute
// state, the free map and the lock/owner store are read, updated and the
// outcome written to the result register. The next request is accepted
// while a result still waits in that register; execution holds only when
// the result register is still full at that point. Alloc picks the lowest
// free slot. After reset every slot is free and unlocked, usable at once.
`default_nettype none

module mutex_pool_lock_unit (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_ready_o,
  input  mpl_pkg::req_t  in_req_i,
  output logic           out_valid_o,
  input  wire            out_ready_i,
  output mpl_pkg::rsp_t  out_rsp_o
);

  mpl_pkg::ctrl_cmd_t cmd;
  mpl_pkg::dp_sts_t   sts;

  mpl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  mpl_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule

`default_nettype wire
